/* hdl/pidaw_pkg.sv */
package pidaw_pkg;

  localparam int DATA_W   = 32;
  localparam int QBITS_DEF = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PC_W      = 4;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP   = 3'd0,
    CFG_GAIN_INTEG  = 3'd1,
    CFG_GAIN_DERIV  = 3'd2,
    CFG_GAIN_WINDUP = 3'd3,
    CFG_OUT_LOWER   = 3'd4,
    CFG_OUT_UPPER   = 3'd5,
    CFG_DERIV_EN    = 3'd6
  } cfg_idx_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_KP,
    MUL_P_KI,
    MUL_KW_SAT,
    MUL_KD_DIFF
  } mul_sel_t;

  // Register transfer done by the adder and clamp logic.
  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_LOAD_P,
    ALU_DIFF,
    ALU_ACC_INT,
    ALU_INT_UPD,
    ALU_SUM,
    ALU_ADD_D,
    ALU_CLAMP,
    ALU_CLEAR
  } alu_op_t;

  typedef struct packed {
    mul_sel_t        mul;
    alu_op_t         alu;
    logic            jump_pi;  // jump to target when the derivative term is off
    logic [PC_W-1:0] target;
    logic            emit;     // final step: writes the result word
  } cw_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic    exec;
    logic    load_in;
    mul_sel_t mul;
    alu_op_t alu;
  } ctl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic deriv_en;
    logic out_full;
  } stat_t;

  localparam logic [PC_W-1:0] PC_START = 4'd0;
  localparam logic [PC_W-1:0] PC_CLAMP = 4'd7;
  localparam logic [PC_W-1:0] PC_CLEAR = 4'd8;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Microprogram. A product is registered by the step that selects its operands
  // and read by a later step; steps 3 and 4 multiply while adding the last product.
  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t w;
    w = '{mul: MUL_NONE, alu: ALU_NOP, jump_pi: 1'b0, target: PC_START, emit: 1'b0};
    case (pc)
      4'd0: w.mul = MUL_ERR_KP;
      4'd1: w.alu = ALU_LOAD_P;
      4'd2: begin
        w.mul = MUL_P_KI;
        w.alu = ALU_DIFF;
      end
      4'd3: begin
        w.mul = MUL_KW_SAT;
        w.alu = ALU_ACC_INT;
      end
      4'd4: begin
        w.mul = MUL_KD_DIFF;
        w.alu = ALU_INT_UPD;
      end
      4'd5: begin
        w.alu     = ALU_SUM;
        w.jump_pi = 1'b1;
        w.target  = PC_CLAMP;
      end
      4'd6: w.alu = ALU_ADD_D;
      4'd7: begin
        w.alu  = ALU_CLAMP;
        w.emit = 1'b1;
      end
      4'd8: begin
        w.alu  = ALU_CLEAR;
        w.emit = 1'b1;
      end
      default: begin
        w.alu  = ALU_CLEAR;
        w.emit = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* hdl/pidaw_if.sv */
interface pidaw_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [32-1:0]      error_in;

  modport source(output valid, output cmd, output error_in, input ready);
  modport sink(input valid, input cmd, input error_in, output ready);
endinterface

interface pidaw_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [32-1:0]      drive_out;
  logic                      clamp_high;
  logic                      clamp_low;

  modport source(output valid, output drive_out, output clamp_high, output clamp_low,
                 input ready);
  modport sink(input valid, input drive_out, input clamp_high, input clamp_low,
               output ready);
endinterface

/* hdl/pid_controller_antiwindup_unit.sv */
// Fixed-point PID controller with back-calculation anti-windup. Each input
// word carries an error sample (or, with cmd set, a clear request) and gives
// exactly one result word: the clamped drive and two flags telling whether the
// upper or the lower limit was hit. Products are taken at 32 x 32 bits, shifted
// right arithmetically by QBITS and cut to 32 bits; every sum wraps. The block
// works on one word at a time under a small microprogram that steers a single
// shared multiplier and its product register. A control step runs eight
// microcode steps, four of them multiplications, and returns to idle before
// the next word can be taken; in PI mode the step that adds the derivative
// term is skipped, and a clear runs a single step. The result sits in an
// output register, so it may wait for the consumer while the next word is
// already accepted; the final microcode step holds only if an older result is
// still unread. Gains and limits are written through the configuration port;
// the user must do so only while the block is idle, which the block does not
// enforce, and they take effect with the next word. After reset the gains are
// zero, the limits span the full range and the derivative term is enabled.
module pid_controller_antiwindup_unit #(
  parameter int QBITS = pidaw_pkg::QBITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pidaw_in_if.sink                            in_ch,
  pidaw_out_if.source                         out_ch,
  input  logic                                cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidaw_pkg::DATA_W-1:0]        cfg_wdata
);
  import pidaw_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  logic  in_ready;

  assign in_ch.ready = in_ready;

  // Step counter and microcode table.
  pidaw_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Multiplier, adder, clamp, state and configuration registers.
  pidaw_dp #(
    .QBITS (QBITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .stat      (stat),
    .in_error  (in_ch.error_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_drive (out_ch.drive_out),
    .out_high  (out_ch.clamp_high),
    .out_low   (out_ch.clamp_low)
  );

endmodule

/* hdl/pidaw_seq.sv */
module pidaw_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_ready,
  input  pidaw_pkg::stat_t stat,
  output pidaw_pkg::ctl_t  ctl
);
  import pidaw_pkg::*;

  seq_state_t      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  cw_t             cw;
  logic            stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pc_r    <= PC_START;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_comb begin
    cw          = ucode(pc_r);
    in_ready    = (state_r == SEQ_IDLE);
    // The final step waits while the result register still holds a word.
    stall       = cw.emit && stat.out_full;
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    ctl.exec    = 1'b0;
    ctl.load_in = 1'b0;
    ctl.mul     = cw.mul;
    ctl.alu     = cw.alu;
    case (state_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_nxt   = SEQ_RUN;
          pc_nxt      = in_cmd ? PC_CLEAR : PC_START;
        end
      end
      SEQ_RUN: begin
        if (!stall) begin
          ctl.exec = 1'b1;
          if (cw.emit) begin
            state_nxt = SEQ_IDLE;
          end else if (cw.jump_pi && !stat.deriv_en) begin
            pc_nxt = cw.target;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

endmodule

/* hdl/pidaw_dp.sv */
module pidaw_dp #(
  parameter int QBITS = pidaw_pkg::QBITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pidaw_pkg::ctl_t                     ctl,
  output pidaw_pkg::stat_t                    stat,
  input  logic signed [pidaw_pkg::DATA_W-1:0] in_error,
  input  logic                                cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidaw_pkg::DATA_W-1:0]        cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pidaw_pkg::DATA_W-1:0] out_drive,
  output logic                                out_high,
  output logic                                out_low
);
  import pidaw_pkg::*;

  // Configuration registers.
  logic signed [DATA_W-1:0] kp_r, ki_r, kd_r, kw_r, lower_r, upper_r;
  logic                     deriv_en_r;

  // Controller state kept between items.
  logic signed [DATA_W-1:0] integ_r, sat_r, prev_r;

  // Working registers of one step.
  logic signed [DATA_W-1:0]   err_r, p_r, diff_r, acc_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [DATA_W-1:0]   drive_r;
  logic                       high_r, low_r, out_valid_r;

  logic signed [DATA_W-1:0] mul_a, mul_b, q, drive_nxt;
  logic                     high_nxt, low_nxt;
  logic                     load_out;

  always_comb begin
    case (ctl.mul)
      MUL_ERR_KP:  begin mul_a = err_r; mul_b = kp_r;   end
      MUL_P_KI:    begin mul_a = p_r;   mul_b = ki_r;   end
      MUL_KW_SAT:  begin mul_a = kw_r;  mul_b = sat_r;  end
      MUL_KD_DIFF: begin mul_a = kd_r;  mul_b = diff_r; end
      default:     begin mul_a = err_r; mul_b = kp_r;   end
    endcase
  end

  // Arithmetic shift right by QBITS, then keep the low word.
  assign q = prod_r[QBITS+DATA_W-1:QBITS];

  // The final step of a control step or a clear writes the result register.
  assign load_out = ctl.exec && ((ctl.alu == ALU_CLAMP) || (ctl.alu == ALU_CLEAR));

  // Upper limit is tested first, so crossed limits give the upper one.
  always_comb begin
    high_nxt  = 1'b0;
    low_nxt   = 1'b0;
    drive_nxt = acc_r;
    if (acc_r > upper_r) begin
      drive_nxt = upper_r;
      high_nxt  = 1'b1;
    end else if (acc_r < lower_r) begin
      drive_nxt = lower_r;
      low_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      kw_r        <= '0;
      lower_r     <= {1'b1, {(DATA_W-1){1'b0}}};
      upper_r     <= {1'b0, {(DATA_W-1){1'b1}}};
      deriv_en_r  <= 1'b1;
      integ_r     <= '0;
      sat_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_PROP:   kp_r       <= cfg_wdata;
          CFG_GAIN_INTEG:  ki_r       <= cfg_wdata;
          CFG_GAIN_DERIV:  kd_r       <= cfg_wdata;
          CFG_GAIN_WINDUP: kw_r       <= cfg_wdata;
          CFG_OUT_LOWER:   lower_r    <= cfg_wdata;
          CFG_OUT_UPPER:   upper_r    <= cfg_wdata;
          CFG_DERIV_EN:    deriv_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.exec) begin
        case (ctl.alu)
          ALU_INT_UPD: integ_r <= acc_r + q;
          ALU_ADD_D:   prev_r  <= p_r;
          ALU_CLAMP:   sat_r   <= drive_nxt - acc_r;
          ALU_CLEAR: begin
            integ_r <= '0;
            sat_r   <= '0;
            prev_r  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // The product register only changes on steps that start a multiplication,
  // so a product survives a step without one.
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      err_r <= in_error;
    end
    if (ctl.exec) begin
      if (ctl.mul != MUL_NONE) begin
        prod_r <= mul_a * mul_b;
      end
      case (ctl.alu)
        ALU_LOAD_P:  p_r    <= q;
        ALU_DIFF:    diff_r <= p_r - prev_r;
        ALU_ACC_INT: acc_r  <= integ_r + q;
        ALU_SUM:     acc_r  <= p_r + integ_r;
        ALU_ADD_D:   acc_r  <= acc_r + q;
        ALU_CLAMP: begin
          drive_r <= drive_nxt;
          high_r  <= high_nxt;
          low_r   <= low_nxt;
        end
        ALU_CLEAR: begin
          drive_r <= '0;
          high_r  <= 1'b0;
          low_r   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign stat.deriv_en = deriv_en_r;
  assign stat.out_full = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_drive     = drive_r;
  assign out_high      = high_r;
  assign out_low       = low_r;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Self-checking bench for the fixed-point PID controller with back-calculation
// anti-windup. A short table of directed words runs first, then a long random
// part under a series of gain and limit settings. Every accepted input word is
// run through a local copy of the controller arithmetic, and the outcome is
// queued; every result word that the block hands over is compared with the
// oldest entry of that queue.
module tb_top;
  import pidaw_pkg::*;

  // Command codes carried in the cmd field of an input word.
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Index 7 is not mapped; writes to it must leave every register untouched.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam int QB          = QBITS_DEF;
  localparam int CYCLE_LIMIT = 250000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 70;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               high;
    logic               low;
  } result_t;

  typedef struct packed {
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic signed [31:0] kw;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               den;
  } gain_set_t;

  // One row of the directed table. Where fixed_want is set, the result is
  // written out by hand; otherwise the local controller copy supplies it.
  typedef struct {
    int                 set_id;
    logic               op;
    logic signed [31:0] err;
    logic               fixed_want;
    result_t            want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  pidaw_in_if  in_ch ();
  pidaw_out_if out_ch ();

  pid_controller_antiwindup_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // The settings the block holds after reset.
  localparam gain_set_t RESET_GAINS = '{kp: 32'sd0, ki: 32'sd0, kd: 32'sd0, kw: 32'sd0,
                                        lo: S32_MIN, hi: S32_MAX, den: 1'b1};

  // Settings used by the directed table. Set 0 is the reset state and is
  // never written, so the first rows check the reset values of the registers.
  gain_set_t dir_sets [6] = '{
    RESET_GAINS,
    // Unity proportional gain, narrow limits: the output follows the error
    // until it is clamped.
    '{32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0, -32'sd1000, 32'sd1000, 1'b1},
    // Unity proportional gain, full range, PI mode.
    '{32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0, S32_MIN, S32_MAX, 1'b0},
    // All four gains at work, limits at plus and minus 2^20.
    '{32'sh0001_8000, 32'sh0000_2000, 32'sh0000_8000, 32'sh0000_4000,
      -32'sd1048576, 32'sd1048576, 1'b1},
    // Crossed limits in PI mode: the upper test wins.
    '{32'sh0001_0000, 32'sh0000_1000, 32'sh0002_0000, 32'sh0000_8000,
      32'sd1000, -32'sd1000, 1'b0},
    // Extreme gains, so that every product and sum wraps.
    '{S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MIN, S32_MAX, 1'b1}
  };

  localparam result_t R_ZERO = '{drive: 32'sd0, high: 1'b0, low: 1'b0};

  stim_row_t dir_rows [25] = '{
    // Reset gains: any error gives a zero drive.
    '{0, OP_STEP,  S32_MAX,        1'b1, R_ZERO},
    '{0, OP_STEP,  S32_MIN,        1'b1, R_ZERO},
    '{0, OP_CLEAR, 32'sd0,         1'b1, R_ZERO},
    // Narrow limits: both clamps, a value inside and one right on the limit.
    '{1, OP_STEP,  S32_MAX,        1'b1, '{32'sd1000, 1'b1, 1'b0}},
    '{1, OP_STEP,  S32_MIN,        1'b1, '{-32'sd1000, 1'b0, 1'b1}},
    '{1, OP_STEP,  32'sd500,       1'b1, '{32'sd500, 1'b0, 1'b0}},
    '{1, OP_STEP,  32'sd1000,      1'b1, '{32'sd1000, 1'b0, 1'b0}},
    '{1, OP_CLEAR, 32'sh1234_5678, 1'b1, R_ZERO},
    // Full range with unity gain: the extremes pass straight through.
    '{2, OP_STEP,  S32_MAX,        1'b1, '{S32_MAX, 1'b0, 1'b0}},
    '{2, OP_STEP,  S32_MIN,        1'b1, '{S32_MIN, 1'b0, 1'b0}},
    '{2, OP_STEP,  -32'sd1,        1'b1, '{-32'sd1, 1'b0, 1'b0}},
    // Full PID with wind-up feedback, then a clear in the middle of it.
    '{3, OP_STEP,  S32_MAX,        1'b0, R_ZERO},
    '{3, OP_STEP,  S32_MAX,        1'b0, R_ZERO},
    '{3, OP_STEP,  32'sh4000_0000, 1'b0, R_ZERO},
    '{3, OP_STEP,  S32_MIN,        1'b0, R_ZERO},
    '{3, OP_STEP,  32'sd0,         1'b0, R_ZERO},
    '{3, OP_CLEAR, S32_MIN,        1'b1, R_ZERO},
    '{3, OP_STEP,  32'sd12345,     1'b0, R_ZERO},
    // Crossed limits.
    '{4, OP_STEP,  32'sd5000,      1'b0, R_ZERO},
    '{4, OP_STEP,  -32'sd5000,     1'b0, R_ZERO},
    '{4, OP_STEP,  32'sd0,         1'b0, R_ZERO},
    '{4, OP_CLEAR, -32'sd1,        1'b1, R_ZERO},
    // Wrapping arithmetic.
    '{5, OP_STEP,  S32_MIN,        1'b0, R_ZERO},
    '{5, OP_STEP,  S32_MAX,        1'b0, R_ZERO},
    '{5, OP_STEP,  32'sh5555_5555, 1'b0, R_ZERO}
  };

  // Local copy of the settings and of the controller state.
  gain_set_t          live_gains = RESET_GAINS;
  logic signed [31:0] integ_acc  = 32'sd0;
  logic signed [31:0] sat_err    = 32'sd0;
  logic signed [31:0] prev_p     = 32'sd0;

  // Results still owed by the block, oldest first.
  result_t pending_drive [$];

  int fail_count  = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int rx_tick     = 0;
  int rx_mode     = 0;

  // The clock runs at 500 MHz with an even duty cycle.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Fixed-point product: full 64-bit signed product, arithmetic shift right by
  // the number of fractional bits, then the low 32 bits.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] wide;
    wide = a * b;
    wide = wide >>> QB;
    return wide[31:0];
  endfunction

  // One controller step on the local state. All 32-bit sums wrap.
  function automatic result_t pid_step(input logic op, input logic signed [31:0] e);
    result_t            r;
    logic signed [31:0] p;
    logic signed [31:0] total;
    r = R_ZERO;
    if (op == OP_CLEAR) begin
      integ_acc = 32'sd0;
      sat_err   = 32'sd0;
      prev_p    = 32'sd0;
      return r;
    end
    p         = fx_mul(e, live_gains.kp);
    integ_acc = integ_acc + fx_mul(p, live_gains.ki) + fx_mul(live_gains.kw, sat_err);
    total     = p + integ_acc;
    if (live_gains.den) begin
      total  = total + fx_mul(live_gains.kd, p - prev_p);
      prev_p = p;
    end
    // The upper limit is tested first, which settles crossed limits.
    if (total > live_gains.hi) begin
      r.drive = live_gains.hi;
      r.high  = 1'b1;
    end else if (total < live_gains.lo) begin
      r.drive = live_gains.lo;
      r.low   = 1'b1;
    end else begin
      r.drive = total;
    end
    sat_err = r.drive - total;
    return r;
  endfunction

  // Gains are mostly moderate, so that the integrator has room to move before
  // the output saturates; now and then a full-width or extreme value is used.
  function automatic logic signed [31:0] random_gain();
    logic signed [31:0] g;
    case ($urandom_range(0, 7))
      0: g = $urandom();
      1: begin
        case ($urandom_range(0, 2))
          0: g = S32_MIN;
          1: g = S32_MAX;
          default: g = 32'sd0;
        endcase
      end
      default: begin
        g = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 1)) g = -g;
      end
    endcase
    return g;
  endfunction

  function automatic gain_set_t random_gains();
    gain_set_t s;
    s.kp  = random_gain();
    s.ki  = random_gain();
    s.kd  = random_gain();
    s.kw  = random_gain();
    s.den = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: begin
        s.lo = S32_MIN;
        s.hi = S32_MAX;
      end
      1: begin
        s.lo = $urandom_range(0, 32'h0010_0000);
        s.hi = 32'd0 - $urandom_range(0, 32'h0010_0000);
      end
      2: begin
        s.lo = $urandom();
        s.hi = $urandom();
      end
      default: begin
        s.lo = 32'd0 - $urandom_range(32'h400, 32'h0400_0000);
        s.hi = $urandom_range(32'h400, 32'h0400_0000);
      end
    endcase
    return s;
  endfunction

  function automatic logic signed [31:0] random_error();
    logic signed [31:0] e;
    case ($urandom_range(0, 9))
      0: e = $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: e = S32_MIN;
          1: e = S32_MAX;
          2: e = -32'sd1;
          default: e = 32'sd0;
        endcase
      end
      default: begin
        e = $urandom_range(0, 32'h0010_0000);
        if ($urandom_range(0, 1)) e = -e;
      end
    endcase
    return e;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Writes every register, plus one write to the unmapped index, and then
  // takes the new settings into the local copy. The upper bits of the
  // derivative enable are filled with noise; only bit 0 counts.
  task automatic apply_gains(input gain_set_t g);
    write_reg(CFG_GAIN_PROP, g.kp);
    write_reg(CFG_GAIN_INTEG, g.ki);
    write_reg(CFG_GAIN_DERIV, g.kd);
    write_reg(CFG_GAIN_WINDUP, g.kw);
    write_reg(CFG_SPARE_IDX, $urandom());
    write_reg(CFG_OUT_LOWER, g.lo);
    write_reg(CFG_OUT_UPPER, g.hi);
    write_reg(CFG_DERIV_EN, ($urandom() & 32'hFFFF_FFFE) | {31'd0, g.den});
    cfg_we     <= 1'b0;
    live_gains  = g;
  endtask

  // Holds the sender off until every owed result has been handed over. It
  // always lets at least one edge pass, so valid is never lowered and raised
  // again within one time step.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left   = 0;
    do @(posedge clk); while (pending_drive.size() != 0);
  endtask

  // Offers one input word and returns at the edge where it is taken. Words go
  // out in bursts of random length; a new burst may start after a random gap
  // or straight away.
  task automatic send_word(input logic op, input logic signed [31:0] e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= op;
    in_ch.error_in <= e;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // The receiver switches at random between five stall patterns, keyed to rx_tick:
  // always ready, coin toss, mostly stalled, a square wave that follows bit 3 of
  // rx_tick and a long stall broken by a single ready cycle.
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 150 == 0) rx_mode = $urandom_range(0, 4);
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      3: out_ch.ready <= rx_tick[3];
      default: out_ch.ready <= (rx_tick % 32 == 0);
    endcase
  end

  // Result checker: each result word taken from the block is compared field
  // by field with the oldest outstanding prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_drive.size() == 0) begin
        $display("%0t: result word with none expected: drive_out %0d high %0b low %0b",
                 $time, out_ch.drive_out, out_ch.clamp_high, out_ch.clamp_low);
        fail_count++;
      end else begin
        want = pending_drive.pop_front();
        if (out_ch.drive_out !== want.drive) begin
          $display("%0t: drive_out expected %0d, got %0d", $time, want.drive,
                   out_ch.drive_out);
          fail_count++;
        end
        if (out_ch.clamp_high !== want.high) begin
          $display("%0t: clamp_high expected %0b, got %0b", $time, want.high,
                   out_ch.clamp_high);
          fail_count++;
        end
        if (out_ch.clamp_low !== want.low) begin
          $display("%0t: clamp_low expected %0b, got %0b", $time, want.low,
                   out_ch.clamp_low);
          fail_count++;
        end
      end
    end
  end

  // Watchdog. The limit is several times what the slowest correct run needs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    result_t guess;
    logic    op;
    logic signed [31:0] e;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= OP_STEP;
    in_ch.error_in <= 32'sd0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_GAIN_PROP;
    cfg_wdata      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. A change of set in the table waits for the block to go
    // quiet before the registers are rewritten.
    foreach (dir_rows[i]) begin
      if (dir_sets[dir_rows[i].set_id] != live_gains) begin
        settle();
        apply_gains(dir_sets[dir_rows[i].set_id]);
      end
      send_word(dir_rows[i].op, dir_rows[i].err);
      guess = pid_step(dir_rows[i].op, dir_rows[i].err);
      pending_drive.push_back(dir_rows[i].fixed_want ? dir_rows[i].want : guess);
    end

    // Random part. Each phase runs under fresh settings; runs of steps let the
    // integrator and the wind-up feedback build up, with the odd clear mixed in.
    // Now and then the sender waits until the block has handed over everything.
    repeat (RAND_PHASES) begin
      settle();
      apply_gains(random_gains());
      repeat (PHASE_WORDS) begin
        op = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_STEP;
        e  = random_error();
        send_word(op, e);
        pending_drive.push_back(pid_step(op, e));
        if ($urandom_range(0, 59) == 0) settle();
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
